@@ src/great_circle_distance_assert.svh @@
// Assertion macros shared by the checker of the great-circle distance block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// A property checked at every rising edge outside reset.
`define GCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication from one cycle to the next, outside reset.
`define GCD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/gcd_pkg.sv @@
// Constants and tables of the great-circle distance datapath.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package gcd_pkg;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032875;
    localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
    localparam logic [26:0]        RECIP_45        = 27'd95443718;
    localparam logic [29:0]        CIRC_M_Q4       = 30'd640482777;
    localparam logic [24:0]        DIST_MAX        = 25'd20015087;

    // Arctangent of 2^-idx in binary-angle units (2^32 per turn).
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051D;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2E;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2F9;
            15: val = 32'h0000517C;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A2F;
            19: val = 32'h00000517;
            20: val = 32'h0000028B;
            21: val = 32'h00000145;
            22: val = 32'h000000A2;
            23: val = 32'h00000051;
            24: val = 32'h00000028;
            25: val = 32'h00000014;
            26: val = 32'h0000000A;
            27: val = 32'h00000005;
            28: val = 32'h00000002;
            29: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ src/gcd_sincos.sv @@
// Pipelined conversion of a degree value to a binary angle, then sine and
// cosine by a rotation-mode CORDIC, one stage per iteration. Uses gcd_pkg.
`timescale 1ns / 1ps

module gcd_sincos #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [25:0] deg_in,
    output logic signed [31:0] sin_out,
    output logic signed [31:0] cos_out
);
    import gcd_pkg::*;

    // Stage 1: magnitude and its quotient by 45.
    logic [25:0] mag;
    logic [52:0] quot_prod;
    logic [25:0] s1_mag_reg;
    logic [20:0] s1_quot_reg;
    logic        s1_neg_reg;

    assign mag       = deg_in[25] ? 26'(-deg_in) : 26'(deg_in);
    assign quot_prod = 53'(mag) * 53'(RECIP_45);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= mag;
            s1_quot_reg <= quot_prod[52:32];
            s1_neg_reg  <= deg_in[25];
        end
    end

    // Stage 2: the remainder sets the fractional part of the scaled angle.
    // mag * 65536 / 360 splits as 8192 * quot + (8192 * rem + 22) / 45.
    logic [25:0] rem_full;
    logic [18:0] frac_num;
    logic [20:0] s2_quot_reg;
    logic [18:0] s2_frac_reg;
    logic        s2_neg_reg;

    assign rem_full = s1_mag_reg - 26'(s1_quot_reg * 26'd45);
    assign frac_num = {rem_full[5:0], 13'b0} + 19'd22;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_quot_reg <= s1_quot_reg;
            s2_frac_reg <= frac_num;
            s2_neg_reg  <= s1_neg_reg;
        end
    end

    // Stage 3: unsigned binary angle, taken modulo a turn.
    logic [45:0] frac_prod;
    logic [31:0] bang_mag;
    logic [31:0] s3_bang_reg;
    logic        s3_neg_reg;

    assign frac_prod = 46'(s2_frac_reg) * 46'(RECIP_45);
    assign bang_mag  = 32'({s2_quot_reg, 13'b0}) + 32'(frac_prod[45:32]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_bang_reg <= bang_mag;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // Stage 4: sign, then the quadrant and the residual angle about it.
    logic [31:0]        bang;
    logic [31:0]        bang_off;
    logic signed [31:0] cz [0:CORDIC_STEPS];
    logic signed [31:0] cx [0:CORDIC_STEPS];
    logic signed [31:0] cy [0:CORDIC_STEPS];
    logic [1:0]         cq [0:CORDIC_STEPS];

    assign bang     = s3_neg_reg ? 32'd0 - s3_bang_reg : s3_bang_reg;
    assign bang_off = bang + 32'h2000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq[0] <= bang_off[31:30];
            cz[0] <= $signed({2'b00, bang_off[29:0]}) - 32'sh2000_0000;
        end
    end

    assign cx[0] = CORDIC_GAIN_Q30;
    assign cy[0] = 32'sd0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [31:0]        step_atan;

        assign dx        = cy[i] >>> i;
        assign dy        = cx[i] >>> i;
        assign step_atan = atan_entry(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cq[i + 1] <= cq[i];
                if (!cz[i][31])
                begin
                    cx[i + 1] <= cx[i] - dx;
                    cy[i + 1] <= cy[i] + dy;
                    cz[i + 1] <= cz[i] - $signed(step_atan);
                end
                else
                begin
                    cx[i + 1] <= cx[i] + dx;
                    cy[i + 1] <= cy[i] - dy;
                    cz[i + 1] <= cz[i] + $signed(step_atan);
                end
            end
        end
    end

    // Final stage: fold the quadrant back in.
    logic signed [31:0] fx;
    logic signed [31:0] fy;

    assign fx = cx[CORDIC_STEPS];
    assign fy = cy[CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (cq[CORDIC_STEPS])
                2'd0:
                begin
                    cos_out <= fx;
                    sin_out <= fy;
                end
                2'd1:
                begin
                    cos_out <= -fy;
                    sin_out <= fx;
                end
                2'd2:
                begin
                    cos_out <= -fx;
                    sin_out <= -fy;
                end
                default:
                begin
                    cos_out <= fy;
                    sin_out <= -fx;
                end
            endcase
        end
    end

endmodule

@@ src/gcd_acos.sv @@
// Pipelined arc cosine of a Q30 value by a bit-per-stage square root and a
// vectoring-mode CORDIC, scaled to metres and saturated. Uses gcd_pkg.
`timescale 1ns / 1ps

module gcd_acos #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] cos_in,
    output logic [24:0]        dist_out
);
    import gcd_pkg::*;

    localparam int SQRT_STEPS = 31;

    // Square of the cosine, then 1 - c^2 at Q60.
    logic signed [63:0] cos_sq;
    logic [60:0]        a1_sq_reg;
    logic signed [31:0] a1_cos_reg;

    assign cos_sq = cos_in * cos_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_sq_reg  <= cos_sq[60:0];
            a1_cos_reg <= cos_in;
        end
    end

    logic [60:0]        rn [0:SQRT_STEPS];
    logic [60:0]        rr [0:SQRT_STEPS];
    logic signed [31:0] rc [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn[0] <= (61'd1 << 60) - a1_sq_reg;
            rr[0] <= 61'd0;
            rc[0] <= a1_cos_reg;
        end
    end

    // One result bit per stage, from the top bit pair down.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [60:0] bit_val;
        logic [61:0] trial;
        logic        fits;

        assign bit_val = 61'd1 << (60 - 2 * k);
        assign trial   = {1'b0, rr[k]} + {1'b0, bit_val};
        assign fits    = {1'b0, rn[k]} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rc[k + 1] <= rc[k];
                if (fits)
                begin
                    rn[k + 1] <= rn[k] - trial[60:0];
                    rr[k + 1] <= (rr[k] >> 1) + bit_val;
                end
                else
                begin
                    rn[k + 1] <= rn[k];
                    rr[k + 1] <= rr[k] >> 1;
                end
            end
        end
    end

    // Start vector: for a negative cosine, begin a quarter turn on.
    logic signed [33:0] vx [0:CORDIC_STEPS];
    logic signed [33:0] vy [0:CORDIC_STEPS];
    logic signed [33:0] vz [0:CORDIC_STEPS];
    logic signed [33:0] sine_w;
    logic signed [33:0] cos_w;

    assign sine_w = $signed({3'b000, rr[SQRT_STEPS][30:0]});
    assign cos_w  = 34'(rc[SQRT_STEPS]);

    always_comb
    begin
        if (cos_w < 0)
        begin
            vx[0] = sine_w;
            vy[0] = -cos_w;
            vz[0] = 34'sd1073741824;
        end
        else
        begin
            vx[0] = cos_w;
            vy[0] = sine_w;
            vz[0] = 34'sd0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] step_atan;

        assign dx        = vy[i] >>> i;
        assign dy        = vx[i] >>> i;
        assign step_atan = $signed({2'b00, atan_entry(i)});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!vy[i][33])
                begin
                    vx[i + 1] <= vx[i] + dx;
                    vy[i + 1] <= vy[i] - dy;
                    vz[i + 1] <= vz[i] + step_atan;
                end
                else
                begin
                    vx[i + 1] <= vx[i] - dx;
                    vy[i + 1] <= vy[i] + dy;
                    vz[i + 1] <= vz[i] - step_atan;
                end
            end
        end
    end

    // Clamp the angle to a half turn and scale by the circumference.
    logic signed [33:0] z_fin;
    logic [31:0]        ang;
    logic [61:0]        scale_reg;

    assign z_fin = vz[CORDIC_STEPS];

    always_comb
    begin
        if (z_fin < 0)
            ang = 32'd0;
        else if (z_fin > 34'sd2147483648)
            ang = 32'h8000_0000;
        else
            ang = z_fin[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            scale_reg <= 62'(ang) * 62'(CIRC_M_Q4);
    end

    logic [61:0] rounded;

    assign rounded = scale_reg + (62'd1 << 35);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rounded[61:36] > 26'(DIST_MAX))
                dist_out <= DIST_MAX;
            else
                dist_out <= rounded[60:36];
        end
    end

endmodule

@@ src/great_circle_distance.sv @@
// Great-circle distance between two points on a sphere of radius 6371 km.
// Input channel: in_valid / in_stall with lat_a, lon_a, lat_b, lon_b, each in
// signed degrees times 65536. A transaction moves when valid is high and
// stall is low. Output channel: out_valid / out_stall with distance_m, the
// distance in whole metres, saturated at half the circumference.
// Every input transaction gives exactly one output transaction, in order.
// Throughput: one transaction per cycle unless the output stalls. The pipeline
// depth is set by the two CORDIC pipelines (one stage per iteration) and the
// 31-stage square root inside the arc cosine.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall goes high in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits only; the block then accepts at once.
// Depends on gcd_pkg, gcd_sincos and gcd_acos.
`timescale 1ns / 1ps

module great_circle_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_b,
    input  logic signed [24:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [24:0]        distance_m
);
    import gcd_pkg::*;

    localparam int SC_LAT = CORDIC_STEPS + 5;
    localparam int AC_LAT = CORDIC_STEPS + 35;
    localparam int LAT    = SC_LAT + AC_LAT + 4;

    logic en;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign en        = !(valid_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = valid_reg[LAT-1];

    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Input register; the longitude difference wraps later as a binary angle.
    logic signed [25:0] lat_a_reg;
    logic signed [25:0] lat_b_reg;
    logic signed [25:0] dlon_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_a_reg <= 26'(lat_a);
            lat_b_reg <= 26'(lat_b);
            dlon_reg  <= 26'(lon_a) - 26'(lon_b);
        end
    end

    logic signed [31:0] sin_a;
    logic signed [31:0] cos_a;
    logic signed [31:0] sin_b;
    logic signed [31:0] cos_b;
    logic signed [31:0] cos_d;

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_a (
        .clk     (clk),
        .en      (en),
        .deg_in  (lat_a_reg),
        .sin_out (sin_a),
        .cos_out (cos_a)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_b (
        .clk     (clk),
        .en      (en),
        .deg_in  (lat_b_reg),
        .sin_out (sin_b),
        .cos_out (cos_b)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_d (
        .clk     (clk),
        .en      (en),
        .deg_in  (dlon_reg),
        .sin_out (),
        .cos_out (cos_d)
    );

    // Cosine sum over three stages: two multiplier levels, then the clamped sum.
    logic signed [63:0] m1_ss_reg;
    logic signed [63:0] m1_cc_reg;
    logic signed [31:0] m1_cd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_ss_reg <= sin_a * sin_b;
            m1_cc_reg <= cos_a * cos_b;
            m1_cd_reg <= cos_d;
        end
    end

    logic signed [33:0] cc_q30;
    logic signed [63:0] m2_ss_reg;
    logic signed [65:0] m2_ccd_reg;

    assign cc_q30 = m1_cc_reg[63:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_ss_reg  <= m1_ss_reg;
            m2_ccd_reg <= cc_q30 * m1_cd_reg;
        end
    end

    logic signed [66:0] sum_q60;
    logic signed [36:0] sum_q30;
    logic signed [31:0] m3_sum_reg;

    assign sum_q60 = 67'(m2_ss_reg) + 67'(m2_ccd_reg);
    assign sum_q30 = sum_q60[66:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sum_q30 > 37'(ONE_Q30))
                m3_sum_reg <= ONE_Q30;
            else if (sum_q30 < -37'(ONE_Q30))
                m3_sum_reg <= -ONE_Q30;
            else
                m3_sum_reg <= sum_q30[31:0];
        end
    end

    gcd_acos #(.CORDIC_STEPS(CORDIC_STEPS)) u_acos (
        .clk      (clk),
        .en       (en),
        .cos_in   (m3_sum_reg),
        .dist_out (distance_m)
    );

endmodule

@@ src/gcd_checker.sv @@
// Port-level checks of the great-circle distance block, bound to the top.
// Uses the macros of great_circle_distance_assert.svh and gcd_pkg.
`timescale 1ns / 1ps
`include "great_circle_distance_assert.svh"

module gcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [24:0] distance_m
);
    import gcd_pkg::*;

    // The input side only stalls behind a result that is itself stalled.
    `GCD_ASSERT(a_stall_cause, in_stall == (out_valid && out_stall), "in_stall without output stall")

    `GCD_ASSERT(a_dist_range, !out_valid || (distance_m <= DIST_MAX), "distance above half circumference")

    `GCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

    `GCD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(distance_m), "stalled result changed")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
